// File: hw/rtl/oltvd_pkg.sv
// ----------------------------------------------------------------------------
// oltvd_pkg
// Shared constants and codes for the ordered list with tail and value delete.
// ----------------------------------------------------------------------------
`default_nettype none

package oltvd_pkg;

    localparam int DEPTH   = 16;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;

    typedef enum logic [1:0] {
        KIND_APPEND    = 2'd0,
        KIND_POP_TAIL  = 2'd1,
        KIND_DEL_VALUE = 2'd2,
        KIND_NONE      = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

endpackage

`default_nettype wire

// File: hw/rtl/oltvd_ram.sv
// ----------------------------------------------------------------------------
// oltvd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module oltvd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/ordered_list_tail_and_value_delete.sv
// ----------------------------------------------------------------------------
// ordered_list_tail_and_value_delete
// Bounded ordered list of signed 32-bit values with append, tail removal and
// removal of the first entry equal to a given value.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready carries s_kind and s_value. Each transfer
//   yields exactly one result transfer on m_valid/m_ready carrying
//   m_removed_value, m_status, m_count and m_empty_res.
//   Entries live in one RAM with a registered read port. Append, unused
//   kinds and removals from an empty list go from idle straight to the done
//   step; remove tail passes through a tail-read step first. Remove by value
//   walks the list once from the head with a single comparator, reading one
//   entry a cycle and writing each later entry back one place down. The
//   result is presented in the same cycle as the next item can be accepted.
//   s_ready is high only while no item is in progress. A finished result
//   waits in the output register; a stalled receiver holds the block in its
//   final step until the register frees, after which the next item is taken.
//   Reset (aresetn low, synchronous) empties the list and drops any pending
//   result; RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_tail_and_value_delete (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [1:0]                       s_kind,
    input  wire logic signed [31:0]               s_value,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [31:0]                    m_removed_value,
    output logic [1:0]                            m_status,
    output logic [oltvd_pkg::COUNT_W-1:0]         m_count,
    output logic                                  m_empty_res
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_TAIL = 4'b0010,
        S_WALK = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                                state_reg, state_next;
    logic [oltvd_pkg::COUNT_W-1:0]         count_reg, count_next;
    logic [oltvd_pkg::COUNT_W-1:0]         rd_cnt_reg, rd_cnt_next;
    logic [oltvd_pkg::ADDR_W-1:0]          cmp_idx_reg, cmp_idx_next;
    logic                                  cmp_valid_reg, cmp_valid_next;
    logic                                  found_reg, found_next;
    logic [oltvd_pkg::DATA_W-1:0]          value_reg, value_next;
    logic [oltvd_pkg::DATA_W-1:0]          res_value_reg, res_value_next;
    oltvd_pkg::status_t                    res_status_reg, res_status_next;

    logic                                  m_valid_reg, m_valid_next;
    logic [oltvd_pkg::DATA_W-1:0]          m_value_reg, m_value_next;
    logic [1:0]                            m_status_reg, m_status_next;
    logic [oltvd_pkg::COUNT_W-1:0]         m_count_reg, m_count_next;

    logic                                  ram_we;
    logic [oltvd_pkg::ADDR_W-1:0]          ram_waddr;
    logic [oltvd_pkg::DATA_W-1:0]          ram_wdata;
    logic [oltvd_pkg::ADDR_W-1:0]          ram_raddr;
    logic [oltvd_pkg::DATA_W-1:0]          ram_rdata;

    logic                                  accept;
    logic                                  issue;
    logic                                  out_free;
    logic [oltvd_pkg::COUNT_W-1:0]         count_dec;
    logic [oltvd_pkg::ADDR_W-1:0]          cmp_idx_dec;
    oltvd_pkg::kind_t                      kind_in;

    assign kind_in     = oltvd_pkg::kind_t'(s_kind);
    assign s_ready     = (state_reg == S_IDLE);
    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign count_dec   = count_reg - {{(oltvd_pkg::COUNT_W-1){1'b0}}, 1'b1};
    assign cmp_idx_dec = cmp_idx_reg - {{(oltvd_pkg::ADDR_W-1){1'b0}}, 1'b1};
    assign issue       = (state_reg == S_WALK) && (rd_cnt_reg < count_reg);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_cnt_next     = rd_cnt_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_valid_next  = 1'b0;
        found_next      = found_reg;
        value_next      = value_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[oltvd_pkg::ADDR_W-1:0];
        ram_wdata       = s_value;
        ram_raddr       = count_dec[oltvd_pkg::ADDR_W-1:0];
        m_valid_next    = m_valid_reg && !m_ready;
        m_value_next    = m_value_reg;
        m_status_next   = m_status_reg;
        m_count_next    = m_count_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    value_next      = s_value;
                    res_value_next  = '0;
                    res_status_next = oltvd_pkg::STATUS_DONE;
                    found_next      = 1'b0;
                    rd_cnt_next     = '0;
                    state_next      = S_DONE;
                    case (kind_in)
                        oltvd_pkg::KIND_APPEND: begin
                            if (count_reg >= oltvd_pkg::COUNT_W'(oltvd_pkg::DEPTH)) begin
                                res_status_next = oltvd_pkg::STATUS_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                count_next = count_reg + oltvd_pkg::COUNT_W'(1);
                            end
                        end
                        oltvd_pkg::KIND_POP_TAIL: begin
                            if (count_reg == '0) begin
                                res_status_next = oltvd_pkg::STATUS_EMPTY;
                            end else begin
                                count_next = count_dec;
                                state_next = S_TAIL;
                            end
                        end
                        oltvd_pkg::KIND_DEL_VALUE: begin
                            if (count_reg == '0) begin
                                res_status_next = oltvd_pkg::STATUS_EMPTY;
                            end else begin
                                state_next = S_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TAIL: begin
                res_value_next = ram_rdata;
                state_next     = S_DONE;
            end
            S_WALK: begin
                ram_raddr = rd_cnt_reg[oltvd_pkg::ADDR_W-1:0];
                if (issue) begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_cnt_reg[oltvd_pkg::ADDR_W-1:0];
                    rd_cnt_next    = rd_cnt_reg + oltvd_pkg::COUNT_W'(1);
                end
                // entries after the match move one place towards the head
                if (cmp_valid_reg) begin
                    if (found_reg) begin
                        ram_we    = 1'b1;
                        ram_waddr = cmp_idx_dec;
                        ram_wdata = ram_rdata;
                    end else if (ram_rdata == value_reg) begin
                        found_next     = 1'b1;
                        res_value_next = ram_rdata;
                    end
                end
                if (!issue && !cmp_valid_reg) begin
                    state_next = S_DONE;
                    if (found_reg) begin
                        count_next = count_dec;
                    end else begin
                        res_status_next = oltvd_pkg::STATUS_NOT_FOUND;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = res_value_reg;
                    m_status_next = res_status_reg;
                    m_count_next  = count_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            rd_cnt_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
            rd_cnt_reg    <= rd_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg    <= cmp_idx_next;
        value_reg      <= value_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_value_reg    <= m_value_next;
        m_status_reg   <= m_status_next;
        m_count_reg    <= m_count_next;
    end

    oltvd_ram #(
        .WIDTH (oltvd_pkg::DATA_W),
        .DEPTH (oltvd_pkg::DEPTH)
    ) u_entries (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_valid         = m_valid_reg;
    assign m_removed_value = m_value_reg;
    assign m_status        = m_status_reg;
    assign m_count         = m_count_reg;
    assign m_empty_res     = (m_count_reg == '0);

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= oltvd_pkg::COUNT_W'(oltvd_pkg::DEPTH))
        else $error("entry count exceeds depth");

    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (rd_cnt_reg <= count_reg))
        else $error("walk read beyond list end");

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && kind_in == oltvd_pkg::KIND_APPEND &&
         count_reg < oltvd_pkg::COUNT_W'(oltvd_pkg::DEPTH))
        |=> (count_reg == $past(count_reg) + oltvd_pkg::COUNT_W'(1)))
        else $error("append did not grow the list");

    a_shift_after_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg == S_WALK) |-> found_reg)
        else $error("entry moved before a match");

    a_fail_no_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != oltvd_pkg::STATUS_DONE) |-> (m_removed_value == '0))
        else $error("failed operation returned a value");
`endif

endmodule

`default_nettype wire

// File: dv/tb_ordered_list_tail_and_value_delete.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_list_tail_and_value_delete
// Self-checking bench for the bounded ordered list. A short directed run walks
// the empty, full, not-found, duplicate and unused-kind cases and the field
// extremes. A long random run follows, in segments biased toward filling or
// draining the list. Deletes mostly name a value that is present. Every
// accepted transfer is run through a local list model, and each result is
// checked against the oldest expected reply. Both sides idle at random.
// ----------------------------------------------------------------------------

module tb_ordered_list_tail_and_value_delete;

    localparam int N_RANDOM    = 1250;
    localparam int CYCLE_LIMIT = 200000;
    localparam int QUIET_FROM  = 4000;
    localparam int QUIET_TO    = 9000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct packed {
        oltvd_pkg::kind_t             kind;
        logic [oltvd_pkg::DATA_W-1:0] value;
    } list_op_t;

    typedef struct packed {
        logic [oltvd_pkg::DATA_W-1:0]  removed;
        oltvd_pkg::status_t            status;
        logic [oltvd_pkg::COUNT_W-1:0] count;
        logic                          empty;
    } list_reply_t;

    typedef struct packed {
        logic [oltvd_pkg::DEPTH-1:0][oltvd_pkg::DATA_W-1:0] slot;
        int unsigned                                        n;
    } list_t;

    logic                                aclk    = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    oltvd_pkg::kind_t                    s_kind  = oltvd_pkg::KIND_APPEND;
    logic signed [oltvd_pkg::DATA_W-1:0] s_value = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic signed [oltvd_pkg::DATA_W-1:0] m_removed_value;
    logic [1:0]                          m_status;
    logic [oltvd_pkg::COUNT_W-1:0]       m_count;
    logic                                m_empty_res;

    list_op_t    pending_ops[$];
    list_reply_t expected_replies[$];

    list_t       gen_list;
    list_t       dut_list;
    list_op_t    drv_op;
    list_op_t    acc_op;
    list_reply_t acc_reply;
    list_reply_t exp_reply;

    int unsigned cycle_count = 0;
    int unsigned errors      = 0;
    int unsigned n_kind[4];
    int unsigned n_status[4];
    int unsigned peak_fill   = 0;

    ordered_list_tail_and_value_delete dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_removed_value (m_removed_value),
        .m_status        (m_status),
        .m_count         (m_count),
        .m_empty_res     (m_empty_res)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic list_apply(inout list_t l, input list_op_t op, output list_reply_t r);
        int unsigned pos;
        r.removed = '0;
        r.status  = oltvd_pkg::STATUS_DONE;
        case (op.kind)
            oltvd_pkg::KIND_APPEND: begin
                if (l.n >= oltvd_pkg::DEPTH) begin
                    r.status = oltvd_pkg::STATUS_FULL;
                end else begin
                    l.slot[l.n] = op.value;
                    l.n++;
                end
            end
            oltvd_pkg::KIND_POP_TAIL: begin
                if (l.n == 0) begin
                    r.status = oltvd_pkg::STATUS_EMPTY;
                end else begin
                    l.n--;
                    r.removed = l.slot[l.n];
                end
            end
            oltvd_pkg::KIND_DEL_VALUE: begin
                if (l.n == 0) begin
                    r.status = oltvd_pkg::STATUS_EMPTY;
                end else begin
                    pos = l.n;
                    for (int unsigned i = 0; i < l.n; i++)
                        if (pos == l.n && l.slot[i] == op.value) pos = i;
                    if (pos == l.n) begin
                        r.status = oltvd_pkg::STATUS_NOT_FOUND;
                    end else begin
                        r.removed = l.slot[pos];
                        for (int unsigned i = pos; i + 1 < l.n; i++)
                            l.slot[i] = l.slot[i + 1];
                        l.n--;
                    end
                end
            end
            default: ;
        endcase
        r.count = oltvd_pkg::COUNT_W'(l.n);
        r.empty = (l.n == 0);
    endtask

    task automatic queue_op(input oltvd_pkg::kind_t k, input logic [oltvd_pkg::DATA_W-1:0] v);
        list_op_t    op;
        list_reply_t r;
        op.kind  = k;
        op.value = v;
        pending_ops.push_back(op);
        list_apply(gen_list, op, r);
    endtask

    // small values give duplicates, so first-match ordering gets exercised
    function automatic logic [oltvd_pkg::DATA_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)
            return oltvd_pkg::DATA_W'($urandom_range(7)) - oltvd_pkg::DATA_W'(4);
        if (r < 80) return $urandom;
        case ($urandom_range(3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic bit idle_now();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
        return $urandom_range(99) < 11;
    endfunction

    // driver: predicts on each accepted transfer, then presents the next op
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                acc_op.kind  = s_kind;
                acc_op.value = s_value;
                list_apply(dut_list, acc_op, acc_reply);
                expected_replies.push_back(acc_reply);
                n_kind[s_kind]++;
                if (dut_list.n > peak_fill) peak_fill = dut_list.n;
            end
            if (!s_valid || s_ready) begin
                if (pending_ops.size() != 0 && !idle_now()) begin
                    drv_op = pending_ops.pop_front();
                    s_valid <= 1'b1;
                    s_kind  <= drv_op.kind;
                    s_value <= drv_op.value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected result transfer: removed %h status %0d count %0d",
                                 m_removed_value, m_status, m_count);
                    errors++;
                end else begin
                    exp_reply = expected_replies.pop_front();
                    n_status[exp_reply.status]++;
                    if (m_removed_value !== exp_reply.removed ||
                        m_status !== exp_reply.status ||
                        m_count !== exp_reply.count ||
                        m_empty_res !== exp_reply.empty) begin
                        if (errors < 10) begin
                            $display("mismatch at cycle %0d: exp removed %h status %0d %s %0d %s %b",
                                     cycle_count, exp_reply.removed, exp_reply.status,
                                     "count", exp_reply.count, "empty", exp_reply.empty);
                            $display("    got removed %h status %0d count %0d empty %b",
                                     m_removed_value, m_status, m_count, m_empty_res);
                        end
                        errors++;
                    end
                end
            end
            m_ready <= !idle_now();
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int unsigned bias;
        int unsigned r;
        gen_list = '0;
        dut_list = '0;

        // empty list and unused kind
        queue_op(oltvd_pkg::KIND_POP_TAIL, 32'h0000_0000);
        queue_op(oltvd_pkg::KIND_DEL_VALUE, 32'h7FFF_FFFF);
        queue_op(oltvd_pkg::KIND_NONE, 32'hFFFF_FFFF);
        // fill to the brim with extremes and a duplicate pair
        queue_op(oltvd_pkg::KIND_APPEND, 32'h7FFF_FFFF);
        queue_op(oltvd_pkg::KIND_APPEND, 32'h8000_0000);
        queue_op(oltvd_pkg::KIND_APPEND, 32'h0000_0000);
        queue_op(oltvd_pkg::KIND_APPEND, 32'hFFFF_FFFF);
        queue_op(oltvd_pkg::KIND_APPEND, 32'h0000_0007);
        queue_op(oltvd_pkg::KIND_APPEND, 32'h0000_0007);
        for (int i = 0; i < 9; i++)
            queue_op(oltvd_pkg::KIND_APPEND, 32'h0100_0000 * i + 32'hAA);
        queue_op(oltvd_pkg::KIND_APPEND, 32'h5555_AAAA);
        queue_op(oltvd_pkg::KIND_APPEND, 32'h1234_5678);
        // first of two duplicates, head, tail, missing value
        queue_op(oltvd_pkg::KIND_DEL_VALUE, 32'h0000_0007);
        queue_op(oltvd_pkg::KIND_DEL_VALUE, 32'h7FFF_FFFF);
        queue_op(oltvd_pkg::KIND_DEL_VALUE, 32'h5555_AAAA);
        queue_op(oltvd_pkg::KIND_DEL_VALUE, 32'hDEAD_BEEF);
        queue_op(oltvd_pkg::KIND_POP_TAIL, 32'hFFFF_FFFF);
        queue_op(oltvd_pkg::KIND_NONE, 32'h0000_0000);

        bias = 50;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 50 == 0) begin
                case ($urandom_range(2))
                    0: bias = 15;
                    1: bias = 50;
                    default: bias = 85;
                endcase
            end
            r = $urandom_range(99);
            if (r < 3) begin
                queue_op(oltvd_pkg::KIND_NONE, $urandom);
            end else if ($urandom_range(99) < bias) begin
                queue_op(oltvd_pkg::KIND_APPEND, pick_value());
            end else if ($urandom_range(1) == 0) begin
                queue_op(oltvd_pkg::KIND_POP_TAIL, $urandom);
            end else if (gen_list.n != 0 && $urandom_range(3) != 0) begin
                queue_op(oltvd_pkg::KIND_DEL_VALUE,
                         gen_list.slot[$urandom_range(gen_list.n - 1)]);
            end else begin
                queue_op(oltvd_pkg::KIND_DEL_VALUE, pick_value());
            end
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_ops.size() != 0 || s_valid || expected_replies.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (expected_replies.size() != 0) begin
            $display("%0d expected results never arrived", expected_replies.size());
            errors++;
        end

        $display("ran %0d appends, %0d tail removals, %0d value removals, %0d unused kinds",
                 n_kind[oltvd_pkg::KIND_APPEND], n_kind[oltvd_pkg::KIND_POP_TAIL],
                 n_kind[oltvd_pkg::KIND_DEL_VALUE], n_kind[oltvd_pkg::KIND_NONE]);
        $display("outcomes: %0d done, %0d empty, %0d full, %0d not found; peak fill %0d",
                 n_status[oltvd_pkg::STATUS_DONE], n_status[oltvd_pkg::STATUS_EMPTY],
                 n_status[oltvd_pkg::STATUS_FULL], n_status[oltvd_pkg::STATUS_NOT_FOUND],
                 peak_fill);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", errors);
            $display("status: fail");
        end
        $finish;
    end

endmodule
